>>> design/clipped_alpha_sprite_blit_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the clipped alpha sprite blit unit
// Shared concurrent assertion forms, clocked on clk_i and quiet during reset.
// ----------------------------------------------------------------------------
`ifndef CLIPPED_ALPHA_SPRITE_BLIT_UNIT_DEFINES_SVH
`define CLIPPED_ALPHA_SPRITE_BLIT_UNIT_DEFINES_SVH

// Property checked on every rising edge outside reset.
`define CSB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Implication checked on every rising edge outside reset.
`define CSB_ASSERT_IMPL(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Implication whose consequent is checked in the next cycle.
`define CSB_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

>>> design/csb_pkg.sv
// ----------------------------------------------------------------------------
// csb_pkg
// Types, register indexes and the channel blend for the sprite blit unit.
// ----------------------------------------------------------------------------
`default_nettype none

package csb_pkg;

  // Configuration register indexes.
  localparam logic [2:0] RegSpriteWidth  = 3'd0;
  localparam logic [2:0] RegSpriteHeight = 3'd1;
  localparam logic [2:0] RegPosX         = 3'd2;
  localparam logic [2:0] RegPosY         = 3'd3;
  localparam logic [2:0] RegScreenWidth  = 3'd4;
  localparam logic [2:0] RegScreenHeight = 3'd5;

  // Screen sizes above this value saturate to it.
  localparam int MaxScreenDim = 2048;

  // Alpha value that replaces the pixel outright.
  localparam logic [7:0] AlphaOpaque = 8'd255;

  // One input item: texel colour and the screen pixel it lands on.
  typedef struct packed {
    logic [7:0] tex_red;
    logic [7:0] tex_green;
    logic [7:0] tex_blue;
    logic [7:0] tex_alpha;
    logic [7:0] dst_red;
    logic [7:0] dst_green;
    logic [7:0] dst_blue;
  } csb_in_t;

  // One result item: the pixel write.
  typedef struct packed {
    logic        write_en;
    logic [21:0] pixel_index;
    logic [7:0]  out_red;
    logic [7:0]  out_green;
    logic [7:0]  out_blue;
    logic        last_texel;
  } csb_out_t;

  // Item held in the input stage, with its screen position already resolved.
  typedef struct packed {
    csb_in_t     pix;
    logic        visible;
    logic        last;
    logic [11:0] sx;
    logic [11:0] sy;
  } csb_stage_t;

  // dst + floor(alpha * (src - dst) / 256), kept to eight bits.
  function automatic logic [7:0] csb_blend(input logic [7:0] src,
                                           input logic [7:0] dst,
                                           input logic [7:0] alpha);
    logic signed [8:0]  diff;
    logic signed [17:0] prod;
    logic signed [17:0] shifted;
    diff    = $signed({1'b0, src}) - $signed({1'b0, dst});
    prod    = $signed({1'b0, alpha}) * diff;
    shifted = prod >>> 8;
    return dst + shifted[7:0];
  endfunction

endpackage

`default_nettype wire

>>> design/clipped_alpha_sprite_blit_unit.sv
// ----------------------------------------------------------------------------
// clipped_alpha_sprite_blit_unit
// Clips sprite texels against the screen and alpha-blends them onto it.
// ----------------------------------------------------------------------------
// The unit takes one texel item per clock unless the output stalls, and returns
// one pixel write item for each via the input stage and result registers. The
// first stage places the texel on the screen from the sprite column and row
// counters and decides clipping and the end of the sprite; the second holds the
// pixel address multiply and the three channel blend multiplies, and its result
// register lets a new item enter while a result waits. Configuration is to be
// written between sprites while the unit is idle (unenforced); it applies at once.
`default_nettype none
`include "clipped_alpha_sprite_blit_unit_defines.svh"

module clipped_alpha_sprite_blit_unit
  import csb_pkg::*;
#(
  parameter int MAX_SPRITE_DIM = 1024
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration write channel
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [11:0] cfg_data_i,
  // Texel items in
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire csb_in_t     in_item_i,
  // Pixel write items out
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output csb_out_t         out_item_o
);

  localparam int CntW  = $clog2(MAX_SPRITE_DIM);
  localparam int DimW  = (CntW + 1 > 11) ? CntW + 1 : 11;
  localparam int CrdW  = 14;

  // Configuration registers
  logic [10:0] sprite_width_q, sprite_height_q;
  logic [11:0] pos_x_q, pos_y_q, screen_width_q, screen_height_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sprite_width_q  <= 11'd1;
      sprite_height_q <= 11'd1;
      pos_x_q         <= 12'd0;
      pos_y_q         <= 12'd0;
      screen_width_q  <= 12'd1;
      screen_height_q <= 12'd1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        RegSpriteWidth:  sprite_width_q  <= cfg_data_i[10:0];
        RegSpriteHeight: sprite_height_q <= cfg_data_i[10:0];
        RegPosX:         pos_x_q         <= cfg_data_i;
        RegPosY:         pos_y_q         <= cfg_data_i;
        RegScreenWidth:  screen_width_q  <= cfg_data_i;
        RegScreenHeight: screen_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Effective sizes: sprite sizes clamp to 1..MAX_SPRITE_DIM, screen sizes to MaxScreenDim.
  logic [DimW-1:0] sw_ext, sh_ext, sw_last, sh_last;
  logic [11:0]     scw, sch;

  always_comb begin
    sw_ext = DimW'(sprite_width_q);
    sh_ext = DimW'(sprite_height_q);
    if (sw_ext == '0) begin
      sw_last = '0;
    end else if (sw_ext > DimW'(MAX_SPRITE_DIM)) begin
      sw_last = DimW'(MAX_SPRITE_DIM - 1);
    end else begin
      sw_last = sw_ext - DimW'(1);
    end
    if (sh_ext == '0) begin
      sh_last = '0;
    end else if (sh_ext > DimW'(MAX_SPRITE_DIM)) begin
      sh_last = DimW'(MAX_SPRITE_DIM - 1);
    end else begin
      sh_last = sh_ext - DimW'(1);
    end
    scw = ({1'b0, screen_width_q} > 13'(MaxScreenDim)) ? 12'(MaxScreenDim)
                                                       : screen_width_q;
    sch = ({1'b0, screen_height_q} > 13'(MaxScreenDim)) ? 12'(MaxScreenDim)
                                                        : screen_height_q;
  end

  // Handshake: each stage frees when empty or when its item moves on.
  logic        s1_valid_q, out_valid_q;
  logic        out_free, s1_free, in_acc, s1_move;

  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_free    = !s1_valid_q || out_free;
  assign in_ready_o = s1_free;
  assign in_acc     = in_valid_i && in_ready_o;
  assign s1_move    = s1_valid_q && out_free;

  // Texel position in the sprite and on the screen.
  logic [CntW-1:0]       col_q, row_q, col_d, row_d;
  logic signed [CrdW-1:0] sx, sy;
  logic                  end_row, last_d, visible;

  always_comb begin
    sx = $signed({{(CrdW-12){pos_x_q[11]}}, pos_x_q})
       + $signed({{(CrdW-CntW){1'b0}}, col_q});
    sy = $signed({{(CrdW-12){pos_y_q[11]}}, pos_y_q})
       + $signed({{(CrdW-CntW){1'b0}}, row_q});
    visible = !sx[CrdW-1] && !sy[CrdW-1]
           && (sx[CrdW-2:0] < (CrdW-1)'(scw))
           && (sy[CrdW-2:0] < (CrdW-1)'(sch));
    end_row = DimW'(col_q) >= sw_last;
    last_d  = end_row && (DimW'(row_q) >= sh_last);
    if (last_d) begin
      col_d = '0;
      row_d = '0;
    end else if (end_row) begin
      col_d = '0;
      row_d = row_q + CntW'(1);
    end else begin
      col_d = col_q + CntW'(1);
      row_d = row_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_acc) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Input stage register.
  csb_stage_t s1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_free) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q.pix     <= in_item_i;
      s1_q.visible <= visible;
      s1_q.last    <= last_d;
      s1_q.sx      <= sx[11:0];
      s1_q.sy      <= sy[11:0];
    end
  end

  // Pixel address and blend of the held item.
  logic [23:0] row_base;
  logic [24:0] addr;
  csb_out_t    res_d, out_q;

  always_comb begin
    row_base = s1_q.sy * scw;
    addr     = {1'b0, row_base} + 25'(s1_q.sx);
    res_d    = '0;
    res_d.last_texel = s1_q.last;
    if (s1_q.visible) begin
      res_d.pixel_index = addr[21:0];
      if (s1_q.pix.tex_alpha == AlphaOpaque) begin
        res_d.write_en  = 1'b1;
        res_d.out_red   = s1_q.pix.tex_red;
        res_d.out_green = s1_q.pix.tex_green;
        res_d.out_blue  = s1_q.pix.tex_blue;
      end else if (s1_q.pix.tex_alpha == '0) begin
        res_d.out_red   = s1_q.pix.dst_red;
        res_d.out_green = s1_q.pix.dst_green;
        res_d.out_blue  = s1_q.pix.dst_blue;
      end else begin
        res_d.write_en  = 1'b1;
        res_d.out_red   = csb_blend(s1_q.pix.tex_red, s1_q.pix.dst_red,
                                    s1_q.pix.tex_alpha);
        res_d.out_green = csb_blend(s1_q.pix.tex_green, s1_q.pix.dst_green,
                                    s1_q.pix.tex_alpha);
        res_d.out_blue  = csb_blend(s1_q.pix.tex_blue, s1_q.pix.dst_blue,
                                    s1_q.pix.tex_alpha);
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      out_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // The input side only stalls when both stages hold an item.
  `CSB_ASSERT_IMPL(a_stall_full, !in_ready_o, s1_valid_q && out_valid_q,
                   "input stalled while a stage is empty")

  // After the final texel of the sprite both counters start over.
  `CSB_ASSERT_NEXT(a_wrap, in_acc && last_d, col_q == '0 && row_q == '0,
                   "counters did not return to zero after the last texel")

  // A held item waits unchanged while the result register is blocked.
  `CSB_ASSERT_NEXT(a_s1_hold, s1_valid_q && !out_free,
                   s1_valid_q && $stable(s1_q),
                   "input stage item changed while stalled")

  // A clipped texel leaves a result with no write and no address.
  `CSB_ASSERT_NEXT(a_clip, s1_move && !s1_q.visible,
                   !out_q.write_en && out_q.pixel_index == '0,
                   "clipped texel produced a write or an address")

endmodule

`default_nettype wire
